// ===== sv/sbm_pkg.sv =====
`default_nettype none

package sbm_pkg;

    // register select codes, address bits 14:13
    localparam logic [1:0] REG_CTRL = 2'd0;
    localparam logic [1:0] REG_CHR0 = 2'd1;
    localparam logic [1:0] REG_CHR1 = 2'd2;
    localparam logic [1:0] REG_PRG  = 2'd3;

    localparam int unsigned NUM_REGS    = 4;
    localparam int unsigned SHIFT_BITS  = 5;
    localparam logic [4:0]  CTRL_RESET  = 5'h1F;
    localparam logic [4:0]  CTRL_FORCE  = 5'h0C;
    localparam logic [2:0]  SHIFT_LAST  = 3'd4;

    // mirroring codes
    localparam logic [1:0] MIRROR_VERT = 2'd0;
    localparam logic [1:0] MIRROR_ONE  = 2'd2;

    localparam logic [7:0] PRG_LAST_0 = 8'hFE;
    localparam logic [7:0] PRG_LAST_1 = 8'hFF;

    // bank state seen by the cartridge
    typedef struct packed {
        logic [3:0][7:0] prg_bank;
        logic            chr_split_mode;
        logic [4:0]      chr_bank_low;
        logic [4:0]      chr_bank_high;
        logic [1:0]      mirror_code;
    } t_banks;

    typedef logic [NUM_REGS-1:0][4:0] t_regs;

    // bank state after reset
    function automatic t_banks banks_reset();
        t_banks b;
        b.prg_bank       = {PRG_LAST_1, PRG_LAST_0, 8'd1, 8'd0};
        b.chr_split_mode = 1'b0;
        b.chr_bank_low   = 5'd0;
        b.chr_bank_high  = 5'd0;
        b.mirror_code    = MIRROR_VERT;
        return b;
    endfunction

    // bank numbers, chr banking and mirroring from the four registers
    function automatic t_banks recompute(input t_regs regs, input logic prg_512k);
        t_banks     b;
        logic [4:0] ctrl;
        logic [4:0] prg;
        logic [7:0] offset;
        logic [7:0] base32;
        logic [7:0] base16;
        ctrl   = regs[REG_CTRL];
        prg    = regs[REG_PRG];
        offset = prg_512k ? {2'b00, regs[REG_CHR0][4], 5'b00000} : 8'd0;
        base32 = {3'b000, prg[3:1], 2'b00} + offset;
        base16 = {3'b000, prg[3:0], 1'b0} + offset;

        // mirroring
        if (ctrl[1]) begin
            b.mirror_code = {1'b0, ~ctrl[0]};
        end else begin
            b.mirror_code = MIRROR_ONE;
        end

        // prg banking mode
        if (!ctrl[3]) begin
            b.prg_bank = {base32 + 8'd3, base32 + 8'd2, base32 + 8'd1, base32};
        end else if (ctrl[2]) begin
            b.prg_bank = {PRG_LAST_1, PRG_LAST_0, base16 + 8'd1, base16};
        end else begin
            b.prg_bank = {base16 + 8'd1, base16, 8'd1, 8'd0};
        end

        // chr banking
        if (ctrl[4]) begin
            b.chr_split_mode = 1'b1;
            b.chr_bank_low   = regs[REG_CHR0];
            b.chr_bank_high  = regs[REG_CHR1];
        end else begin
            b.chr_split_mode = 1'b0;
            b.chr_bank_low   = {1'b0, regs[REG_CHR0][4:1]};
            b.chr_bank_high  = 5'd0;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sbm_in_if.sv =====
`default_nettype none

// bus write channel
interface sbm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;

    modport source (output valid, output bus_address, output bus_data, input ready);
    modport sink   (input valid, input bus_address, input bus_data, output ready);
endinterface

`default_nettype wire

// ===== sv/sbm_out_if.sv =====
`default_nettype none

// bank result channel
interface sbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] prg_bank_0;
    logic [7:0] prg_bank_1;
    logic [7:0] prg_bank_2;
    logic [7:0] prg_bank_3;
    logic       chr_split_mode;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirror_code;
    logic       committed;

    modport source (
        output valid, output prg_bank_0, output prg_bank_1, output prg_bank_2,
        output prg_bank_3, output chr_split_mode, output chr_bank_low,
        output chr_bank_high, output mirror_code, output committed, input ready
    );
    modport sink (
        input valid, input prg_bank_0, input prg_bank_1, input prg_bank_2,
        input prg_bank_3, input chr_split_mode, input chr_bank_low,
        input chr_bank_high, input mirror_code, input committed, output ready
    );
endinterface

`default_nettype wire

// ===== sv/serial_bank_mapper_controller.sv =====
`default_nettype none

// Serial bank-select controller. Every bus write beat yields exactly one result
// beat holding the current PRG, CHR and mirroring state and a committed flag.
// Bit 0 of each write shifts into a five-bit shifter, LSB first; the fifth bit
// commits it to the register picked by address bits 14:13. A write with bit 7
// set forces control bits 3:2 on and commits at once. The block takes one write
// per cycle: the update is one pass of logic from the state registers into the
// result register, and a new write is taken whenever the result register is
// empty or being drained in the same cycle. i_cfg_wdata
// (the 512K PRG flag) may only change while no beat is in flight.
module serial_bank_mapper_controller (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    sbm_in_if.sink     i_in,
    sbm_out_if.source  o_out
);

    logic              r_prg_512k;
    logic [2:0]        r_shift_count;
    logic [4:0]        r_shift_value;
    sbm_pkg::t_regs    r_regs;
    sbm_pkg::t_banks   r_banks;
    logic              r_out_valid;
    sbm_pkg::t_banks   r_out_banks;
    logic              r_out_committed;

    logic              in_fire;
    logic [1:0]        sel;
    logic [4:0]        shifted;
    logic              commit;
    logic [2:0]        n_shift_count;
    logic [4:0]        n_shift_value;
    sbm_pkg::t_regs    n_regs;
    sbm_pkg::t_banks   n_banks;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign sel        = i_in.bus_address[14:13];

    // shifter and register update for one write beat
    always_comb begin
        shifted       = r_shift_value | (5'(i_in.bus_data[0]) << r_shift_count);
        n_regs        = r_regs;
        n_shift_count = r_shift_count + 3'd1;
        n_shift_value = shifted;
        commit        = 1'b0;
        if (i_in.bus_data[7]) begin
            n_regs[sbm_pkg::REG_CTRL] = r_regs[sbm_pkg::REG_CTRL] | sbm_pkg::CTRL_FORCE;
            commit = 1'b1;
        end else if (r_shift_count == sbm_pkg::SHIFT_LAST) begin
            n_regs[sel] = shifted;
            commit      = 1'b1;
        end
        if (commit) begin
            n_shift_count = 3'd0;
            n_shift_value = 5'd0;
            n_banks       = sbm_pkg::recompute(n_regs, r_prg_512k);
        end else begin
            n_banks = r_banks;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_512k <= 1'b0;
        end else if (i_cfg_we) begin
            r_prg_512k <= i_cfg_wdata;
        end
    end

    // mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_count <= 3'd0;
            r_shift_value <= 5'd0;
            r_regs        <= {5'd0, 5'd0, 5'd0, sbm_pkg::CTRL_RESET};
            r_banks       <= sbm_pkg::banks_reset();
        end else if (in_fire) begin
            r_shift_count <= n_shift_count;
            r_shift_value <= n_shift_value;
            r_regs        <= n_regs;
            r_banks       <= n_banks;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_banks     <= n_banks;
            r_out_committed <= commit;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.prg_bank_0     = r_out_banks.prg_bank[0];
    assign o_out.prg_bank_1     = r_out_banks.prg_bank[1];
    assign o_out.prg_bank_2     = r_out_banks.prg_bank[2];
    assign o_out.prg_bank_3     = r_out_banks.prg_bank[3];
    assign o_out.chr_split_mode = r_out_banks.chr_split_mode;
    assign o_out.chr_bank_low   = r_out_banks.chr_bank_low;
    assign o_out.chr_bank_high  = r_out_banks.chr_bank_high;
    assign o_out.mirror_code    = r_out_banks.mirror_code;
    assign o_out.committed      = r_out_committed;

endmodule

`default_nettype wire
